// File: rtl/core/ipv4_prefix_table_macros.svh
// Assertion macros for the IPv4 prefix table.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef IPV4_PREFIX_TABLE_MACROS_SVH
`define IPV4_PREFIX_TABLE_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define IPT_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property on every rising clock edge, reset included.
`define IPT_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IPT_ASSERT(name, clk, rst, prop, msg)
`define IPT_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// File: rtl/core/ipt_pkg.sv
// Shared types, codes and helper functions for the IPv4 prefix table.
// No dependencies; the interfaces and modules use this package.
package ipt_pkg;

   localparam int MODE_W   = 2;
   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 6;
   localparam int STATUS_W = 2;

   localparam logic [LEN_W-1:0]  MAX_LEN = 6'd32;
   localparam logic [ADDR_W-1:0] TOP_BIT = 32'h8000_0000;

   // operation codes
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

   // result codes
   localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUP    = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ABSENT = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd3;

   typedef struct packed {
      logic              used;
      logic [ADDR_W-1:0] network;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   match_network;
      logic [LEN_W-1:0]    match_length;
   } rsp_type;

   // Contiguous mask of len leading ones; len is at most 32.
   function automatic logic [ADDR_W-1:0] length_to_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] top;
      top = TOP_BIT >> (len - 6'd1);
      if (len == '0) begin
         return '0;
      end
      return ~(top - 32'd1);
   endfunction

   function automatic logic [LEN_W-1:0] saturate_length(input logic [LEN_W-1:0] len);
      return (len > MAX_LEN) ? MAX_LEN : len;
   endfunction

endpackage

// File: rtl/core/ipt_req_if.sv
// Request channel of the IPv4 prefix table: valid/ready plus operation payload.
// Depends on ipt_pkg for field widths.
interface ipt_req_if;
   logic                      valid;
   logic                      ready;
   logic [ipt_pkg::MODE_W-1:0] mode;
   logic [ipt_pkg::ADDR_W-1:0] address;
   logic [ipt_pkg::LEN_W-1:0]  prefix_length;

   modport source (output valid, output mode, output address, output prefix_length,
                   input ready);
   modport sink   (input valid, input mode, input address, input prefix_length,
                   output ready);
endinterface

// File: rtl/core/ipt_rsp_if.sv
// Response channel of the IPv4 prefix table: valid/ready plus result payload.
// Depends on ipt_pkg for field widths.
interface ipt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [ipt_pkg::STATUS_W-1:0] status;
   logic [ipt_pkg::ADDR_W-1:0]   match_network;
   logic [ipt_pkg::LEN_W-1:0]    match_length;

   modport source (output valid, output status, output match_network, output match_length,
                   input ready);
   modport sink   (input valid, input status, input match_network, input match_length,
                   output ready);
endinterface

// File: rtl/core/ipt_engine.sv
// Table memory and scan sequencer of the IPv4 prefix table.
// Depends on ipt_pkg, ipt_req_if and the assertion macro header.
`include "ipv4_prefix_table_macros.svh"
module ipt_engine #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic             clock,
   input  logic             reset,
   ipt_req_if.sink          req_ch,
   output ipt_pkg::rsp_type push_data,
   output logic             push_valid,
   input  logic             push_ready
);
   import ipt_pkg::*;

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_SCAN, ST_FINISH} state_type;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             mem_we;
   logic [IDX_W-1:0] wr_addr;
   entry_type        wr_data;

   state_type         state_ff, state_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [MODE_W-1:0] q_mode_ff, q_mode_in;
   logic [ADDR_W-1:0] q_addr_ff, q_addr_in;
   logic [ADDR_W-1:0] q_net_ff, q_net_in;
   logic [LEN_W-1:0]  q_len_ff, q_len_in;
   logic              found_ff, found_in;
   logic [IDX_W-1:0]  found_idx_ff, found_idx_in;
   logic              free_found_ff, free_found_in;
   logic [IDX_W-1:0]  free_idx_ff, free_idx_in;
   logic              hit_ff, hit_in;
   logic [ADDR_W-1:0] best_net_ff, best_net_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;

   logic              accept;
   logic              last;
   logic              is_exact, is_free, is_contained;
   logic [LEN_W-1:0]  req_len;
   logic              finish_write;
   entry_type         finish_entry;
   logic [IDX_W-1:0]  finish_addr;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign last         = (idx_ff == LAST_IDX);
   assign req_len      = saturate_length(req_ch.prefix_length);

   // classify the entry that arrived from memory this cycle
   assign is_exact     = rd_data_ff.used && (rd_data_ff.network == q_net_ff) &&
                         (rd_data_ff.length == q_len_ff);
   assign is_free      = !rd_data_ff.used;
   assign is_contained = rd_data_ff.used &&
                         ((q_addr_ff & length_to_mask(rd_data_ff.length)) == rd_data_ff.network);

   // result and write-back decision at the end of the scan
   always_comb begin
      push_data    = '{status: STATUS_ABSENT, match_network: '0, match_length: '0};
      finish_write = 1'b0;
      finish_entry = '{used: 1'b0, network: '0, length: '0};
      finish_addr  = found_idx_ff;
      case (q_mode_ff)
         MODE_INSERT: begin
            finish_addr  = free_idx_ff;
            finish_entry = '{used: 1'b1, network: q_net_ff, length: q_len_ff};
            if (found_ff) begin
               push_data.status = STATUS_DUP;
            end else if (!free_found_ff) begin
               push_data.status = STATUS_FULL;
            end else begin
               push_data.status = STATUS_OK;
               finish_write     = 1'b1;
            end
         end
         MODE_REMOVE: begin
            if (found_ff) begin
               push_data.status = STATUS_OK;
               finish_write     = 1'b1;
            end
         end
         MODE_LOOKUP: begin
            if (hit_ff) begin
               push_data = '{status: STATUS_OK, match_network: best_net_ff,
                             match_length: best_len_ff};
            end
         end
         default: begin
            push_data.status = STATUS_ABSENT;
         end
      endcase
   end

   assign push_valid = (state_ff == ST_FINISH);

   // memory ports: read every cycle, write during clear or at the end of an item
   always_comb begin
      rd_addr = (state_ff == ST_IDLE) ? '0 : idx_ff + IDX_W'(1);
      mem_we  = 1'b0;
      wr_addr = idx_ff;
      wr_data = '{used: 1'b0, network: '0, length: '0};
      if (state_ff == ST_CLEAR) begin
         mem_we = 1'b1;
      end else if (state_ff == ST_FINISH && push_ready && finish_write) begin
         mem_we  = 1'b1;
         wr_addr = finish_addr;
         wr_data = finish_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      q_mode_in     = q_mode_ff;
      q_addr_in     = q_addr_ff;
      q_net_in      = q_net_ff;
      q_len_in      = q_len_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      hit_in        = hit_ff;
      best_net_in   = best_net_ff;
      best_len_in   = best_len_ff;
      case (state_ff)
         ST_CLEAR: begin
            idx_in = idx_ff + IDX_W'(1);
            if (last) begin
               state_in = ST_IDLE;
               idx_in   = '0;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in      = ST_SCAN;
               idx_in        = '0;
               q_mode_in     = req_ch.mode;
               q_addr_in     = req_ch.address;
               q_len_in      = req_len;
               q_net_in      = req_ch.address & length_to_mask(req_len);
               found_in      = 1'b0;
               free_found_in = 1'b0;
               hit_in        = 1'b0;
               best_net_in   = '0;
               best_len_in   = '0;
            end
         end
         ST_SCAN: begin
            if (is_exact && !found_ff) begin
               found_in     = 1'b1;
               found_idx_in = idx_ff;
            end
            if (is_free && !free_found_ff) begin
               free_found_in = 1'b1;
               free_idx_in   = idx_ff;
            end
            if (is_contained && (!hit_ff || rd_data_ff.length > best_len_ff)) begin
               hit_in      = 1'b1;
               best_net_in = rd_data_ff.network;
               best_len_in = rd_data_ff.length;
            end
            idx_in = idx_ff + IDX_W'(1);
            if (last) begin
               state_in = ST_FINISH;
               idx_in   = '0;
            end
         end
         ST_FINISH: begin
            if (push_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
      q_mode_ff     <= q_mode_in;
      q_addr_ff     <= q_addr_in;
      q_net_ff      <= q_net_in;
      q_len_ff      <= q_len_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_ff        <= hit_in;
      best_net_ff   <= best_net_in;
      best_len_ff   <= best_len_in;
   end

   `IPT_ASSERT(a_accept_starts_scan, clock, reset, accept |=> (state_ff == ST_SCAN && idx_ff == '0), "accepted transfer did not start a scan at entry zero")
   `IPT_ASSERT(a_scan_advances, clock, reset, (state_ff == ST_SCAN && !last) |=> (state_ff == ST_SCAN && idx_ff == $past(idx_ff) + IDX_W'(1)), "scan index did not advance by one")
   `IPT_ASSERT(a_insert_into_free, clock, reset, (mem_we && state_ff == ST_FINISH && q_mode_ff == MODE_INSERT) |-> (!found_ff && free_found_ff), "insert wrote without a free slot or over a duplicate")
   `IPT_ASSERT(a_hit_length_range, clock, reset, (state_ff == ST_FINISH && q_mode_ff == MODE_LOOKUP && hit_ff) |-> (best_len_ff <= MAX_LEN), "lookup hit carries a length above 32")
   `IPT_ASSERT_ALWAYS(a_no_accept_in_reset, clock, reset |=> !req_ch.ready, "request taken right after reset")

endmodule

// File: rtl/core/ipt_rsp_reg.sv
// Output register of the IPv4 prefix table: holds one result for the rsp channel.
// Depends on ipt_pkg and ipt_rsp_if.
module ipt_rsp_reg (
   input  logic             clock,
   input  logic             reset,
   input  ipt_pkg::rsp_type push_data,
   input  logic             push_valid,
   output logic             push_ready,
   ipt_rsp_if.source        rsp_ch
);
   import ipt_pkg::*;

   rsp_type data_ff;
   logic    valid_ff;

   // take a new result when empty or when the held one leaves this cycle
   assign push_ready = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (push_valid && push_ready) begin
         valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         valid_ff <= 1'b0;
      end
      if (push_valid && push_ready) begin
         data_ff <= push_data;
      end
   end

   assign rsp_ch.valid         = valid_ff;
   assign rsp_ch.status        = data_ff.status;
   assign rsp_ch.match_network = data_ff.match_network;
   assign rsp_ch.match_length  = data_ff.match_length;

endmodule

// File: rtl/core/ipv4_prefix_table.sv
// Top level of the IPv4 prefix table with longest prefix match.
// Depends on ipt_pkg, ipt_req_if, ipt_rsp_if, ipt_engine and ipt_rsp_reg.
//
// Usage:
//   req_ch carries one operation per transfer: mode (insert, remove, look up),
//   address and prefix_length. Lengths above 32 count as 32.
//   rsp_ch returns exactly one result per request, in order: status,
//   match_network and match_length (both zero unless a lookup hits).
//   Every operation scans the whole table once through the single read port
//   of the entry memory, one entry per cycle; a new request is taken only
//   after the result of the previous one has moved to the output register.
//   An insert or remove writes its entry back in the cycle the result
//   moves to the output register.
//   After reset the block clears every entry of the memory and
//   holds req_ch.ready low until that pass is done.
//   When rsp_ch stalls, the output register holds the finished result and
//   the block still takes the next request and scans it; only the hand-off
//   of that second result waits for the output register to drain.
module ipv4_prefix_table #(
   parameter int TABLE_ENTRIES = 64
) (
   input  logic      clock,
   input  logic      reset,
   ipt_req_if.sink   req_ch,
   ipt_rsp_if.source rsp_ch
);
   import ipt_pkg::*;

   rsp_type push_data;
   logic    push_valid;
   logic    push_ready;

   // scan sequencer with the entry memory
   ipt_engine #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   // hold each result until the receiver takes the transfer
   ipt_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
